[rtl/core/scaled_glyph_row_generator_unit_defines.svh]
// Assertion macros shared by the glyph row generator.
// Both expect signals named clk and rst_n in the scope where they are used.
`ifndef SCALED_GLYPH_ROW_GENERATOR_UNIT_DEFINES_SVH
`define SCALED_GLYPH_ROW_GENERATOR_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SGRG_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SGRG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/sgrg_pkg.sv]
package sgrg_pkg;

    localparam int unsigned SCREEN_WIDTH_DEF  = 128;
    localparam int unsigned SCREEN_HEIGHT_DEF = 160;

    localparam logic [7:0] FIRST_CODE = 8'h20;
    localparam logic [7:0] LAST_CODE  = 8'h7E;
    localparam int unsigned NUM_GLYPHS = 95;
    localparam int unsigned GLYPH_COLS = 5;
    localparam int unsigned GLYPH_ROWS = 7;
    localparam int unsigned MASK_W     = 16;

    // Font sizes, named by the height of the character cell.
    localparam logic [1:0] FONT_CELL_8  = 2'd0;
    localparam logic [1:0] FONT_CELL_16 = 2'd1;
    localparam logic [1:0] FONT_CELL_24 = 2'd2;
    localparam logic [1:0] FONT_CELL_32 = 2'd3;

    typedef logic [0:GLYPH_COLS-1][7:0]           glyph_bytes_t;
    typedef logic [GLYPH_COLS-1:0][GLYPH_ROWS-1:0] glyph_t;

    // Everything the mask logic needs to build one cell row.
    typedef struct packed {
        glyph_t     glyph;
        logic [1:0] font_size;
        logic [2:0] grow;       // glyph row, saturates at 7 (below the glyph)
        logic [4:0] width;      // clipped cell width, 1..16
    } row_ctl_t;

    // Column-major 5x7 font, first column in the leftmost byte of each entry.
    localparam logic [39:0] GLYPH_ROM [0:NUM_GLYPHS-1] = '{
        40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
        40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
        40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
        40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
        40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
        40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
        40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
        40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
        40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
        40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
        40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
        40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h2649494932,
        40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4030403F,
        40'h6314081463, 40'h0304780403, 40'h6151494543, 40'h007F414100,
        40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
        40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
        40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h0C5252523E,
        40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h7F10284400,
        40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
        40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
        40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
        40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
        40'h00007F0000, 40'h0041360800, 40'h0804081008
    };

    // Glyph column of each cell column at scale 3.
    localparam logic [3:0] GCOL_SCALE3 [0:MASK_W-1] = '{
        4'd0, 4'd0, 4'd0, 4'd1, 4'd1, 4'd1, 4'd2, 4'd2,
        4'd2, 4'd3, 4'd3, 4'd3, 4'd4, 4'd4, 4'd4, 4'd5
    };

    function automatic logic [4:0] cell_width(input logic [1:0] font_size);
        logic [4:0] w;
        case (font_size)
            FONT_CELL_8:  w = 5'd6;
            FONT_CELL_16: w = 5'd8;
            FONT_CELL_24: w = 5'd12;
            FONT_CELL_32: w = 5'd16;
            default:      w = 5'd6;
        endcase
        return w;
    endfunction

    function automatic logic [5:0] cell_height(input logic [1:0] font_size);
        logic [5:0] h;
        case (font_size)
            FONT_CELL_8:  h = 6'd8;
            FONT_CELL_16: h = 6'd16;
            FONT_CELL_24: h = 6'd24;
            FONT_CELL_32: h = 6'd32;
            default:      h = 6'd8;
        endcase
        return h;
    endfunction

    // Scale minus one: the last value of the sub-row counter.
    function automatic logic [1:0] scale_last(input logic [1:0] font_size);
        logic [1:0] s;
        case (font_size)
            FONT_CELL_8:  s = 2'd0;
            FONT_CELL_16: s = 2'd0;
            FONT_CELL_24: s = 2'd1;
            FONT_CELL_32: s = 2'd2;
            default:      s = 2'd0;
        endcase
        return s;
    endfunction

    function automatic logic [3:0] glyph_col(input logic [1:0] font_size,
                                             input logic [3:0] col);
        logic [3:0] g;
        case (font_size)
            FONT_CELL_8:  g = col;
            FONT_CELL_16: g = col;
            FONT_CELL_24: g = {1'b0, col[3:1]};
            FONT_CELL_32: g = GCOL_SCALE3[col];
            default:      g = col;
        endcase
        return g;
    endfunction

endpackage

[rtl/core/sgrg_row_mask.sv]
module sgrg_row_mask
    import sgrg_pkg::*;
(
    input  row_ctl_t            ctl,
    output logic [MASK_W-1:0]   mask
);

    always_comb
    begin
        logic [3:0] gcol;
        mask = '0;
        for (int k = 0; k < MASK_W; k++)
        begin
            gcol = glyph_col(ctl.font_size, 4'(k));
            if ((5'(k) < ctl.width) && (gcol < 4'(GLYPH_COLS))
                && (ctl.grow < 3'(GLYPH_ROWS)))
            begin
                mask[k] = ctl.glyph[gcol[2:0]][ctl.grow];
            end
        end
    end

endmodule

[rtl/core/scaled_glyph_row_generator_unit.sv]
// A request is held in the cell register; each row word then moves to the output register.
// One row word per cycle while the output is not stalled; a character gives one word per
// clipped row (8, 16, 24 or 32 at most), counted by the row counter of the cell register.
// The next request is taken in the cycle its predecessor's last row moves to the output.
// A request off the screen is taken without loading the cell register and gives no words.
// Reset (rst_n low, asynchronous) empties the cell register and the output register.
`include "scaled_glyph_row_generator_unit_defines.svh"

module scaled_glyph_row_generator_unit
    import sgrg_pkg::*;
#(
    parameter int unsigned SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int unsigned SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    // char_code[7:0], font_size[9:8], pos_x[17:10], pos_y[25:18],
    // fg_color[41:26], bg_color[57:42], zero[63:58]
    input  logic [63:0] s_tdata,

    output logic        m_tvalid,
    input  logic        m_tready,
    // row_y[7:0], start_x[15:8], pixel_mask[31:16], row_width[36:32],
    // fg_out[52:37], bg_out[68:53], zero[71:69]
    output logic [71:0] m_tdata,
    // last_row
    output logic        m_tlast
);

    localparam logic [8:0] SCR_W = 9'(SCREEN_WIDTH);
    localparam logic [8:0] SCR_H = 9'(SCREEN_HEIGHT);

    // Request fields
    logic [7:0]  in_code;
    logic [1:0]  in_font;
    logic [7:0]  in_x;
    logic [7:0]  in_y;
    logic [15:0] in_fg;
    logic [15:0] in_bg;

    assign in_code = s_tdata[7:0];
    assign in_font = s_tdata[9:8];
    assign in_x    = s_tdata[17:10];
    assign in_y    = s_tdata[25:18];
    assign in_fg   = s_tdata[41:26];
    assign in_bg   = s_tdata[57:42];

    // Cell register
    logic        busy_reg,  busy_next;
    glyph_t      glyph_reg, glyph_next;
    logic [1:0]  font_reg,  font_next;
    logic [7:0]  x_reg,     x_next;
    logic [7:0]  y_reg,     y_next;
    logic [15:0] fg_reg,    fg_next;
    logic [15:0] bg_reg,    bg_next;
    logic [4:0]  w_reg,     w_next;
    logic [5:0]  h_reg,     h_next;
    logic [4:0]  row_reg,   row_next;
    logic [2:0]  grow_reg,  grow_next;
    logic [1:0]  sub_reg,   sub_next;

    // Output register
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_row_y_reg;
    logic [7:0]  out_x_reg;
    logic [15:0] out_mask_reg;
    logic [4:0]  out_width_reg;
    logic [15:0] out_fg_reg;
    logic [15:0] out_bg_reg;
    logic        out_last_reg;

    logic         in_accept;
    logic         advance;
    logic         row_last;
    logic         on_screen;
    logic [6:0]   glyph_idx;
    glyph_bytes_t glyph_bytes;
    glyph_t       glyph_new;
    logic [8:0]   room_x;
    logic [8:0]   room_y;
    logic [4:0]   w_new;
    logic [5:0]   h_new;
    row_ctl_t     row_ctl;
    logic [15:0]  row_mask;

    assign advance   = busy_reg && (!out_valid_reg || m_tready);
    assign row_last  = (6'({1'b0, row_reg}) + 6'd1) == h_reg;
    assign s_tready  = !busy_reg || (advance && row_last);
    assign in_accept = s_tvalid && s_tready;

    // Request decode: glyph lookup and clipping of the cell against the screen.
    always_comb
    begin
        if ((in_code < FIRST_CODE) || (in_code > LAST_CODE))
        begin
            glyph_idx = 7'd0;
        end
        else
        begin
            glyph_idx = 7'(in_code - FIRST_CODE);
        end
        glyph_bytes = glyph_bytes_t'(GLYPH_ROM[glyph_idx]);
        for (int g = 0; g < GLYPH_COLS; g++)
        begin
            glyph_new[g] = glyph_bytes[g][GLYPH_ROWS-1:0];
        end

        on_screen = ({1'b0, in_x} < SCR_W) && ({1'b0, in_y} < SCR_H);
        room_x    = SCR_W - {1'b0, in_x};
        room_y    = SCR_H - {1'b0, in_y};
        w_new     = (room_x < {4'd0, cell_width(in_font)})  ? room_x[4:0] : cell_width(in_font);
        h_new     = (room_y < {3'd0, cell_height(in_font)}) ? room_y[5:0] : cell_height(in_font);
    end

    always_comb
    begin
        busy_next  = busy_reg;
        glyph_next = glyph_reg;
        font_next  = font_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        fg_next    = fg_reg;
        bg_next    = bg_reg;
        w_next     = w_reg;
        h_next     = h_reg;
        row_next   = row_reg;
        grow_next  = grow_reg;
        sub_next   = sub_reg;

        if (advance)
        begin
            if (row_last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                row_next = row_reg + 5'd1;
                if (sub_reg == scale_last(font_reg))
                begin
                    sub_next = 2'd0;
                    if (grow_reg != 3'd7)
                    begin
                        grow_next = grow_reg + 3'd1;
                    end
                end
                else
                begin
                    sub_next = sub_reg + 2'd1;
                end
            end
        end

        if (in_accept && on_screen)
        begin
            busy_next  = 1'b1;
            glyph_next = glyph_new;
            font_next  = in_font;
            x_next     = in_x;
            y_next     = in_y;
            fg_next    = in_fg;
            bg_next    = in_bg;
            w_next     = w_new;
            h_next     = h_new;
            row_next   = 5'd0;
            grow_next  = 3'd0;
            sub_next   = 2'd0;
        end
    end

    assign row_ctl.glyph     = glyph_reg;
    assign row_ctl.font_size = font_reg;
    assign row_ctl.grow      = grow_reg;
    assign row_ctl.width     = w_reg;

    sgrg_row_mask u_row_mask
    (
        .ctl  (row_ctl),
        .mask (row_mask)
    );

    always_comb
    begin
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            row_reg       <= '0;
            grow_reg      <= '0;
            sub_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            row_reg       <= row_next;
            grow_reg      <= grow_next;
            sub_reg       <= sub_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        glyph_reg <= glyph_next;
        font_reg  <= font_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        fg_reg    <= fg_next;
        bg_reg    <= bg_next;
        w_reg     <= w_next;
        h_reg     <= h_next;
        if (advance)
        begin
            out_row_y_reg <= y_reg + {3'd0, row_reg};
            out_x_reg     <= x_reg;
            out_mask_reg  <= row_mask;
            out_width_reg <= w_reg;
            out_fg_reg    <= fg_reg;
            out_bg_reg    <= bg_reg;
            out_last_reg  <= row_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0, out_bg_reg, out_fg_reg, out_width_reg, out_mask_reg,
                       out_x_reg, out_row_y_reg};
    assign m_tlast  = out_last_reg;

    `SGRG_ASSERT_SAME(a_row_in_cell, busy_reg, ({1'b0, row_reg} < h_reg), "row index beyond clipped cell height")
    `SGRG_ASSERT_SAME(a_sub_in_scale, busy_reg, (sub_reg <= scale_last(font_reg)), "sub-row counter beyond scale")
    `SGRG_ASSERT_SAME(a_width_range, m_tvalid, ((out_width_reg != 5'd0) && (out_width_reg <= 5'd16)), "row width out of range")
    `SGRG_ASSERT_SAME(a_mask_clipped, m_tvalid, ((out_mask_reg >> out_width_reg) == 16'd0), "mask bit set beyond row width")
    `SGRG_ASSERT_NEXT(a_done_after_last, (advance && row_last && !in_accept), !busy_reg, "cell still busy after its last row")

endmodule
